// ===== sv/pre_pkg.sv =====
`timescale 1ns / 1ps
package pre_pkg;
	// engine dimensions
	localparam int NUM_FRAMES        = 16;
	localparam int NUM_PROCESSES     = 4;
	localparam int PAGES_PER_PROCESS = 64;

	// configuration register indexes
	localparam logic [1:0] REG_POLICY = 2'd0;
	localparam logic [1:0] REG_SCOPE  = 2'd1;
	localparam logic [1:0] REG_QUOTA  = 2'd2;

	// victim policies
	localparam logic [1:0] POL_FIFO = 2'd0;
	localparam logic [1:0] POL_SC   = 2'd1;
	localparam logic [1:0] POL_LFU  = 2'd2;

	// controller commands to the datapath
	typedef struct packed {
		logic load;       // latch request, bump access counters, start table read
		logic tbl_done;   // table read data valid, latch hit and frame, bump use count
		logic scan_start; // prepare free/owner scan
		logic scan_step;  // examine one frame
		logic vic_start;  // prepare victim scan
		logic vic_step;   // examine one frame for the victim
		logic vic_rd;     // read victim's use count (lfu)
		logic commit;     // write back frame, counter and page table updates
		logic clr_step;   // clearing pass step
	} pre_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic hit;
		logic scan_last;
		logic vic_found;
		logic vic_last;
		logic take_free;
		logic clr_last;
		logic lfu;
	} pre_sts_t;
endpackage

// ===== sv/pre_ram.sv =====
`timescale 1ns / 1ps
module pre_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/pre_ctrl.sv =====
`timescale 1ns / 1ps
module pre_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              out_busy,
	output logic              out_load,
	output pre_pkg::pre_cmd_t cmd,
	input  pre_pkg::pre_sts_t sts
);
	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RD    = 4'd2;
	localparam logic [3:0] S_TBL   = 4'd3;
	localparam logic [3:0] S_SCAN  = 4'd4;
	localparam logic [3:0] S_VPREP = 4'd5;
	localparam logic [3:0] S_VIC   = 4'd6;
	localparam logic [3:0] S_VRD   = 4'd7;
	localparam logic [3:0] S_COMM  = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: state_d = S_TBL;
			S_TBL: begin
				cmd.tbl_done   = 1'b1;
				cmd.scan_start = 1'b1;
				state_d        = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit) state_d = S_COMM;
				else begin
					cmd.scan_step = 1'b1;
					if (sts.scan_last) state_d = S_VPREP;
				end
			end
			S_VPREP: begin
				if (sts.take_free) state_d = S_COMM;
				else begin
					cmd.vic_start = 1'b1;
					state_d       = sts.lfu ? S_VRD : S_VIC;
				end
			end
			S_VRD: begin
				// lfu: read the candidate's use count, compare next cycle
				cmd.vic_rd = 1'b1;
				state_d    = S_VIC;
			end
			S_VIC: begin
				cmd.vic_step = 1'b1;
				if (sts.vic_found || sts.vic_last) state_d = S_COMM;
				else if (sts.lfu) state_d = S_VRD;
			end
			S_COMM: begin
				cmd.commit = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_busy) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else         state_q <= state_d;
	end
endmodule

// ===== sv/pre_dp.sv =====
`timescale 1ns / 1ps
module pre_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        policy,
	input  logic              scope,
	input  logic [4:0]        quota,
	input  logic [1:0]        in_proc,
	input  logic [5:0]        in_page,
	input  pre_pkg::pre_cmd_t cmd,
	output pre_pkg::pre_sts_t sts,
	output logic              r_hit,
	output logic [3:0]        r_frame,
	output logic              r_evicted,
	output logic [1:0]        r_vproc,
	output logic [5:0]        r_vpage,
	output logic [31:0]       r_faults,
	output logic [31:0]       r_accesses
);
	localparam int NUM_FRAMES        = pre_pkg::NUM_FRAMES;
	localparam int NUM_PROCESSES     = pre_pkg::NUM_PROCESSES;
	localparam int PAGES_PER_PROCESS = pre_pkg::PAGES_PER_PROCESS;
	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int PW = (NUM_PROCESSES > 1) ? $clog2(NUM_PROCESSES) : 1;
	localparam int GW = (PAGES_PER_PROCESS > 1) ? $clog2(PAGES_PER_PROCESS) : 1;
	localparam int TS = NUM_PROCESSES * PAGES_PER_PROCESS;
	localparam int TW = (TS > 1) ? $clog2(TS) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int SW = FW + 2; // scan counter, up to 2*NUM_FRAMES+1 steps

	// per-frame registers
	logic [NUM_FRAMES-1:0] fvalid_q, fref_q;
	logic [PW-1:0]         fowner_q [NUM_FRAMES];
	logic [GW-1:0]         fpage_q  [NUM_FRAMES];
	logic [31:0]           fstamp_q [NUM_FRAMES];
	// per-process registers
	logic [CW-1:0] pused_q   [NUM_PROCESSES];
	logic [31:0]   pfault_q  [NUM_PROCESSES];
	logic [31:0]   paccess_q [NUM_PROCESSES];
	logic [31:0]   aclock_q;
	logic [FW-1:0] hand_q;

	// request
	logic [PW-1:0] proc_q;
	logic [GW-1:0] page_q;
	logic [TW-1:0] idx_q;
	logic          hit_q;
	logic [FW-1:0] frame_q;

	// page table memory: {present, frame} and separate use counts
	logic [TW-1:0]     clr_idx_q;
	logic              pt_we;
	logic [TW-1:0]     pt_waddr, pt_raddr;
	logic [FW:0]       pt_wdata, pt_rdata;
	logic              uc_we;
	logic [TW-1:0]     uc_waddr, uc_raddr;
	logic [15:0]       uc_wdata, uc_rdata;
	logic              pt_rv_q; // validity of the registered read

	// victim's page table entry is invalidated in the cycle after commit
	logic          inv_q;
	logic [TW-1:0] inv_idx_q;

	// scans
	logic [SW-1:0] cnt_q;
	logic [FW-1:0] pos_q;
	logic          has_free_q, owns_q;
	logic [FW-1:0] free_q;
	logic          only_own_q, found_q;
	logic [31:0]   best_key_q;
	logic          evict_q;

	function automatic logic [TW-1:0] tidx(input logic [PW-1:0] p, input logic [GW-1:0] g);
		logic [TW+PW+GW:0] t;
		t = (TW+PW+GW+1)'(p) * (TW+PW+GW+1)'(PAGES_PER_PROCESS) + (TW+PW+GW+1)'(g);
		return t[TW-1:0];
	endfunction

	pre_ram #(.WIDTH(FW+1), .DEPTH(TS)) u_pt (
		.clk(clk), .we(pt_we), .waddr(pt_waddr), .wdata(pt_wdata),
		.raddr(pt_raddr), .rdata(pt_rdata));
	pre_ram #(.WIDTH(16), .DEPTH(TS)) u_uc (
		.clk(clk), .we(uc_we), .waddr(uc_waddr), .wdata(uc_wdata),
		.raddr(uc_raddr), .rdata(uc_rdata));

	logic [PW-1:0] in_p;
	logic [GW-1:0] in_g;
	assign in_p = PW'(32'(in_proc) % NUM_PROCESSES);
	assign in_g = GW'(32'(in_page) % PAGES_PER_PROCESS);

	logic cand_pos;
	logic [15:0] uc_eff;
	logic [15:0] uc_new;
	logic [FW-1:0] pos_nx;
	assign cand_pos = fvalid_q[pos_q] && (!only_own_q || fowner_q[pos_q] == proc_q);
	assign uc_eff   = pt_rv_q ? uc_rdata : 16'd0;
	assign uc_new   = (uc_eff == 16'hFFFF) ? uc_eff : uc_eff + 16'd1;
	assign pos_nx   = (32'(pos_q) == NUM_FRAMES - 1) ? '0 : pos_q + FW'(1);

	logic [FW-1:0] vf; // final frame
	assign vf = frame_q;

	// memory port control; the request's entry stays addressed after load, except during lfu use-count reads
	always_comb begin
		if (cmd.vic_rd)    pt_raddr = tidx(fowner_q[pos_q], fpage_q[pos_q]);
		else if (cmd.load) pt_raddr = tidx(in_p, in_g);
		else               pt_raddr = idx_q;
		uc_raddr = pt_raddr;
		pt_we = 1'b0; pt_waddr = idx_q; pt_wdata = '0;
		uc_we = 1'b0; uc_waddr = idx_q; uc_wdata = uc_new;
		if (cmd.clr_step) begin
			pt_we = 1'b1; pt_waddr = clr_idx_q;
			uc_we = 1'b1; uc_waddr = clr_idx_q; uc_wdata = '0;
		end else if (inv_q) begin
			pt_we = 1'b1; pt_waddr = inv_idx_q;
		end else if (cmd.tbl_done) begin
			uc_we = 1'b1;
		end else if (cmd.commit && !hit_q) begin
			pt_we = 1'b1; pt_wdata = {1'b1, vf};
		end
	end

	assign sts.hit       = hit_q;
	assign sts.scan_last = 32'(cnt_q) == NUM_FRAMES - 1;
	assign sts.take_free = has_free_q &&
		(!scope || 32'(pused_q[proc_q]) < 32'(quota) || !owns_q);
	assign sts.vic_found = (policy == pre_pkg::POL_SC) && cand_pos && !fref_q[pos_q];
	assign sts.vic_last  = (policy == pre_pkg::POL_SC) ? 32'(cnt_q) == 2 * NUM_FRAMES
		: 32'(cnt_q) == NUM_FRAMES - 1;
	assign sts.clr_last  = 32'(clr_idx_q) == TS - 1;
	assign sts.lfu       = policy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			fvalid_q <= '0; fref_q <= '0;
			for (int i = 0; i < NUM_FRAMES; i++) begin
				fowner_q[i] <= '0; fpage_q[i] <= '0; fstamp_q[i] <= '0;
			end
			for (int i = 0; i < NUM_PROCESSES; i++) begin
				pused_q[i] <= '0; pfault_q[i] <= '0; paccess_q[i] <= '0;
			end
			aclock_q <= '0; hand_q <= '0;
			pt_rv_q <= 1'b0;
		end else begin
			// clearing pass over the page table
			if (cmd.clr_step) clr_idx_q <= clr_idx_q + TW'(1);
			pt_rv_q <= 1'b1;
			if (cmd.load) begin
				if (paccess_q[in_p] != 32'hFFFFFFFF) paccess_q[in_p] <= paccess_q[in_p] + 32'd1;
			end
			// second-chance scan clears reference bits as it passes
			if (cmd.vic_step && policy == pre_pkg::POL_SC && cand_pos && fref_q[pos_q])
				fref_q[pos_q] <= 1'b0;
			if (cmd.vic_step && policy == pre_pkg::POL_SC && cand_pos && !fref_q[pos_q])
				hand_q <= pos_nx;
			if (cmd.commit) begin
				aclock_q <= aclock_q + 32'd1;
				fref_q[vf] <= 1'b1;
				if (!hit_q) begin
					if (pfault_q[proc_q] != 32'hFFFFFFFF) pfault_q[proc_q] <= pfault_q[proc_q] + 32'd1;
					fvalid_q[vf] <= 1'b1;
					fowner_q[vf] <= proc_q;
					fpage_q[vf]  <= page_q;
					fstamp_q[vf] <= aclock_q;
					for (int i = 0; i < NUM_PROCESSES; i++) begin
						if (PW'(i) == proc_q) begin
							if (!(evict_q && fowner_q[vf] == proc_q) && 32'(pused_q[i]) < NUM_FRAMES)
								pused_q[i] <= pused_q[i] + CW'(1);
						end else if (evict_q && PW'(i) == fowner_q[vf] && pused_q[i] != '0) begin
							pused_q[i] <= pused_q[i] - CW'(1);
						end
					end
				end
			end
		end
	end

	// request and scan datapath (payload, no reset needed)
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			proc_q <= in_p; page_q <= in_g; idx_q <= tidx(in_p, in_g);
		end
		if (cmd.tbl_done) begin
			hit_q      <= pt_rv_q && pt_rdata[FW];
			frame_q    <= pt_rdata[FW-1:0];
			evict_q    <= 1'b0;
			r_vproc    <= '0;
			r_vpage    <= '0;
		end
		if (cmd.scan_start) begin
			cnt_q <= '0; pos_q <= FW'(NUM_FRAMES - 1);
			has_free_q <= 1'b0; owns_q <= 1'b0;
		end
		// free/owner scan walks from the top so the lowest free frame wins
		if (cmd.scan_step) begin
			cnt_q <= cnt_q + SW'(1);
			pos_q <= pos_q - FW'(1);
			if (!fvalid_q[pos_q]) begin
				has_free_q <= 1'b1; free_q <= pos_q;
			end else if (fowner_q[pos_q] == proc_q) owns_q <= 1'b1;
		end
		if (sts.take_free && !hit_q && !cmd.tbl_done && !cmd.scan_step && !cmd.vic_step
			&& !evict_q)
			frame_q <= free_q;
		if (cmd.vic_start) begin
			cnt_q <= '0;
			pos_q <= (policy == pre_pkg::POL_SC) ? hand_q : '0;
			only_own_q <= scope && owns_q;
			found_q <= 1'b0;
			evict_q <= 1'b1;
		end
		if (cmd.vic_step) begin
			cnt_q <= cnt_q + SW'(1);
			pos_q <= pos_nx;
			if (policy == pre_pkg::POL_SC) begin
				if (cand_pos && !fref_q[pos_q]) frame_q <= pos_q;
				else frame_q <= pos_nx;
			end else if (cand_pos) begin
				if (!found_q || (policy == pre_pkg::POL_FIFO ? fstamp_q[pos_q]
					: {16'd0, uc_eff}) < best_key_q) begin
					found_q    <= 1'b1;
					frame_q    <= pos_q;
					best_key_q <= (policy == pre_pkg::POL_FIFO) ? fstamp_q[pos_q] : {16'd0, uc_eff};
				end
			end
		end
		if (cmd.commit) begin
			r_hit     <= hit_q;
			r_frame   <= 4'(vf);
			r_evicted <= evict_q;
			if (evict_q) begin
				r_vproc <= 2'(fowner_q[vf]);
				r_vpage <= 6'(fpage_q[vf]);
			end
			r_faults   <= (!hit_q && pfault_q[proc_q] != 32'hFFFFFFFF) ?
				pfault_q[proc_q] + 32'd1 : pfault_q[proc_q];
			r_accesses <= paccess_q[proc_q];
		end
	end

	// victim invalidation pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inv_q <= 1'b0;
		else         inv_q <= cmd.commit && evict_q;
	end
	always_ff @(posedge clk) begin
		if (cmd.commit) inv_idx_q <= tidx(fowner_q[vf], fpage_q[vf]);
	end
endmodule

// ===== sv/page_replacement_engine_top.sv =====
`timescale 1ns / 1ps
// Page replacement engine: one access (process, page) in, one result out.
// Items are taken one at a time. A hit skips the scans; a fault runs a
// free-frame scan of one frame per cycle and, when no free frame is used,
// a victim scan over every frame (fifo), over up to 2*NUM_FRAMES+1 frames
// (second chance, clock hand may pass twice) or over every frame with one
// registered use-count read per frame (lfu). A finished result is held back
// while the previous one still waits on m_tready; no input is taken meanwhile.
// After reset a clearing pass over all NUM_PROCESSES*PAGES_PER_PROCESS
// page table entries runs before the first item is taken.
module page_replacement_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // process_id[1:0], page_number[7:2]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // hit, frame_index[4:1], evicted, victim_process,
	                              // victim_page, fault_total, access_total
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [4:0]  cfg_data
);
	logic [1:0] policy_q;
	logic       scope_q;
	logic [4:0] quota_q;
	pre_pkg::pre_cmd_t cmd;
	pre_pkg::pre_sts_t sts;
	logic out_load;
	logic r_hit, r_ev;
	logic [3:0] r_frame;
	logic [1:0] r_vproc;
	logic [5:0] r_vpage;
	logic [31:0] r_f, r_a;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= pre_pkg::POL_FIFO; scope_q <= 1'b0; quota_q <= 5'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pre_pkg::REG_POLICY: policy_q <= cfg_data[1:0];
				pre_pkg::REG_SCOPE:  scope_q  <= cfg_data[0];
				pre_pkg::REG_QUOTA:  quota_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	pre_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_tvalid), .in_ready(s_tready),
		.out_busy(m_tvalid && !m_tready), .out_load(out_load), .cmd(cmd), .sts(sts));

	pre_dp u_dp (
		.clk(clk), .arst_n(arst_n), .policy(policy_q), .scope(scope_q), .quota(quota_q),
		.in_proc(s_tdata[1:0]), .in_page(s_tdata[7:2]), .cmd(cmd), .sts(sts),
		.r_hit(r_hit), .r_frame(r_frame), .r_evicted(r_ev), .r_vproc(r_vproc),
		.r_vpage(r_vpage), .r_faults(r_f), .r_accesses(r_a));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tvalid <= 1'b0;
		else if (out_load) m_tvalid <= 1'b1;
		else if (m_tready) m_tvalid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) m_tdata <= {2'b00, r_a, r_f, r_vpage, r_vproc, r_ev, r_frame, r_hit};
	end

`ifndef NO_ASSERTIONS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("output dropped");
	a_no_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !cmd.commit) else $error("accept during work");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[5])) else $error("hit with eviction");
`endif
endmodule
